// ----- hw/rtl/sva_pkg.sv -----
// Shared constants, types and the arctangent table of the vector angle block.
// No dependencies; imported by sva_polar and signed_vector_angle.
package sva_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int ANGLE_W     = 16;            // output angle field
  localparam int CW          = 56;            // CORDIC datapath width
  localparam int ZW          = 35;            // signed angle accumulator, Q4.30 plus a sign bit
  localparam int NORM_TOP    = 53;            // normalized magnitude in [2^52, 2^53)
  localparam int NORM_STAGES = 6;             // shifts of 32,16,8,4,2,1
  localparam int STEPS       = 31;
  localparam int POLAR_LAT   = 1 + NORM_STAGES + STEPS;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef struct packed {
    logic degen;   // a vector has zero length
    logic zero;    // sign product is zero
    logic neg;     // sign product is negative
  } flags_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = ZW'(843314856);  1: r = ZW'(497837829);  2: r = ZW'(263043836);
      3: r = ZW'(133525158);  4: r = ZW'(67021686);   5: r = ZW'(33543515);
      6: r = ZW'(16775850);   7: r = ZW'(8388437);    8: r = ZW'(4194282);
      9: r = ZW'(2097149);    10: r = ZW'(1048575);   11: r = ZW'(524287);
      12: r = ZW'(262143);    13: r = ZW'(131071);    14: r = ZW'(65535);
      15: r = ZW'(32767);     16: r = ZW'(16383);     17: r = ZW'(8191);
      18: r = ZW'(4095);      19: r = ZW'(2047);      20: r = ZW'(1023);
      21: r = ZW'(511);       22: r = ZW'(255);       23: r = ZW'(127);
      24: r = ZW'(63);        25: r = ZW'(31);        26: r = ZW'(15);
      27: r = ZW'(8);         28: r = ZW'(4);         29: r = ZW'(2);
      30: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/sva_polar.sv -----
// Pipelined polar angle: quadrant fold, 6-stage normalize, 31 CORDIC steps.
// Depends on sva_pkg. Its registers advance only while en is high.
module sva_polar import sva_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS:0]   x,
  input  logic signed [COORD_BITS:0]   y,
  output logic signed [ZW-1:0]         z
);

  logic signed [CW-1:0]       xe, ye, fx, fy;
  logic signed [ZW-1:0]       fz;
  logic [CW-1:0]              ax, ay;
  logic [NORM_TOP-1:0]        fm;

  logic signed [CW-1:0]       nx [0:NORM_STAGES];
  logic signed [CW-1:0]       ny [0:NORM_STAGES];
  logic signed [ZW-1:0]       nz [0:NORM_STAGES];
  logic [NORM_TOP-1:0]        nm [0:NORM_STAGES];

  logic signed [CW-1:0]       cx [0:STEPS];
  logic signed [CW-1:0]       cy [0:STEPS];
  logic signed [ZW-1:0]       cz [0:STEPS];

  // fold left half plane by a quarter turn
  always_comb begin
    xe = {{(CW-COORD_BITS-1){x[COORD_BITS]}}, x};
    ye = {{(CW-COORD_BITS-1){y[COORD_BITS]}}, y};
    if (xe < 0) begin
      if (ye >= 0) begin
        fx = ye;  fy = -xe; fz = ZW'(HALF_PI_Q30);
      end else begin
        fx = -ye; fy = xe;  fz = -ZW'(HALF_PI_Q30);
      end
    end else begin
      fx = xe; fy = ye; fz = '0;
    end
    ax = (fx < 0) ? -fx : fx;
    ay = (fy < 0) ? -fy : fy;
    fm = (ax > ay) ? ax[NORM_TOP-1:0] : ay[NORM_TOP-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx[0] <= fx;
      ny[0] <= fy;
      nz[0] <= fz;
      nm[0] <= fm;
    end
  end

  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    localparam int AMT = 1 << (NORM_STAGES - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        nz[k+1] <= nz[k];
        if (nm[k][NORM_TOP-1 -: AMT] == '0) begin
          nx[k+1] <= nx[k] <<< AMT;
          ny[k+1] <= ny[k] <<< AMT;
          nm[k+1] <= nm[k] << AMT;
        end else begin
          nx[k+1] <= nx[k];
          ny[k+1] <= ny[k];
          nm[k+1] <= nm[k];
        end
      end
    end
  end

  assign cx[0] = nx[NORM_STAGES];
  assign cy[0] = ny[NORM_STAGES];
  assign cz[0] = nz[NORM_STAGES];

  // y residue of zero steps the same way as negative
  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_q30(i);
        end
      end
    end
  end

  assign z = cz[STEPS];

endmodule

// ----- hw/rtl/signed_vector_angle.sv -----
// Signed angle between heading vector and target vector, fully pipelined.
// Depends on sva_pkg and sva_polar.
//
//  channel  dir  fields (tdata/tuser)                          handshake
//  s_*      in   cur_x,cur_y,head_x,head_y,tgt_x,tgt_y          tvalid/tready
//  m_*      out  angle (tdata), degenerate (tuser)             tvalid/tready
//
// One transaction enters per cycle unless m_tready stalls the output; it
// passes stage 0, the 6-stage normalizer and 31-step CORDIC, then post.
// Synchronous active-high rst clears only valid bits; payload is unreset.
// The whole pipe advances when the output register is empty or drained;
// a stall at m_tready freezes every stage, nothing is dropped or repeated.
module signed_vector_angle import sva_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // cur_x, cur_y, head_x, head_y, tgt_x, tgt_y from bit 0 up, zero padded
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // angle, Q(ANGLE_FRAC_BITS) signed radians
  output logic [ANGLE_W-1:0]                  m_tdata,
  // degenerate
  output logic [0:0]                          m_tuser
);

  localparam int     SH     = 30 - ANGLE_FRAC_BITS;
  localparam longint HALF   = 64'sd1 << (SH - 1);
  localparam longint PI_OUT = (PI_Q30 + HALF) >>> SH;
  localparam int     DW     = ZW + 1;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---- stage 0: unpack, differences, sign and degenerate flags ----
  logic signed [COORD_BITS-1:0] cx_in, cy_in, hx_in, hy_in, tx_in, ty_in;
  logic signed [COORD_BITS:0]   hx_d, hy_d, tx_d, ty_d;
  logic signed [COORD_BITS:0]   hx, hy, tx, ty;
  flags_t                       fl_d, fl0;
  logic                         v0;

  always_comb begin
    cx_in = s_tdata[0*COORD_BITS +: COORD_BITS];
    cy_in = s_tdata[1*COORD_BITS +: COORD_BITS];
    hx_in = s_tdata[2*COORD_BITS +: COORD_BITS];
    hy_in = s_tdata[3*COORD_BITS +: COORD_BITS];
    tx_in = s_tdata[4*COORD_BITS +: COORD_BITS];
    ty_in = s_tdata[5*COORD_BITS +: COORD_BITS];
    hx_d  = (COORD_BITS+1)'(hx_in) - (COORD_BITS+1)'(cx_in);
    hy_d  = (COORD_BITS+1)'(hy_in) - (COORD_BITS+1)'(cy_in);
    tx_d  = (COORD_BITS+1)'(tx_in) - (COORD_BITS+1)'(cx_in);
    ty_d  = (COORD_BITS+1)'(ty_in) - (COORD_BITS+1)'(cy_in);
    fl_d.degen = (hx_d == '0 && hy_d == '0) || (tx_d == '0 && ty_d == '0);
    fl_d.zero  = (tx_d == '0) || (hy_d == '0) || (hx_d == '0);
    fl_d.neg   = tx_d[COORD_BITS] ^ hy_d[COORD_BITS] ^ hx_d[COORD_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hx <= hx_d; hy <= hy_d; tx <= tx_d; ty <= ty_d;
      fl0 <= fl_d;
    end
  end

  // ---- polar angles of both vectors ----
  logic signed [ZW-1:0] zh, zt;

  sva_polar #(.COORD_BITS(COORD_BITS)) u_polar_h (
    .clk(clk), .en(en), .x(hx), .y(hy), .z(zh)
  );
  sva_polar #(.COORD_BITS(COORD_BITS)) u_polar_t (
    .clk(clk), .en(en), .x(tx), .y(ty), .z(zt)
  );

  // valid and flags ride alongside the CORDIC pipe
  logic   vl [0:POLAR_LAT];
  flags_t fl [0:POLAR_LAT];
  assign vl[0] = v0;
  assign fl[0] = fl0;

  for (genvar k = 0; k < POLAR_LAT; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else if (en) begin
        vl[k+1] <= vl[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        fl[k+1] <= fl[k];
      end
    end
  end

  // ---- post: difference, wrap, abs+round, clamp+sign ----
  logic                 va, vb, vc;
  logic                 ka, kb, kc;     // force zero angle
  logic                 na, nb, nc;
  logic                 da, db, dc;     // degenerate
  logic signed [DW-1:0] d_a, d_b;
  logic [DW-1:0]        r_c;
  logic signed [DW-1:0] wrap_d;
  logic [DW-1:0]        abs_d;
  logic [DW-1:0]        q;
  logic [ANGLE_W-1:0]   ang;

  always_comb begin
    if (d_a > DW'(PI_Q30)) begin
      wrap_d = d_a - DW'(2 * PI_Q30);
    end else if (d_a < -DW'(PI_Q30)) begin
      wrap_d = d_a + DW'(2 * PI_Q30);
    end else begin
      wrap_d = d_a;
    end
    abs_d = (d_b < 0) ? DW'(-d_b) : DW'(d_b);
    q     = r_c >> SH;
    if (q > DW'(PI_OUT)) begin
      q = DW'(PI_OUT);
    end
    ang = nc ? -q[ANGLE_W-1:0] : q[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; m_tvalid <= 1'b0;
    end else if (en) begin
      va <= vl[POLAR_LAT]; vb <= va; vc <= vb; m_tvalid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_a <= DW'(zt) - DW'(zh);
      ka  <= fl[POLAR_LAT].degen | fl[POLAR_LAT].zero;
      na  <= fl[POLAR_LAT].neg;
      da  <= fl[POLAR_LAT].degen;
      d_b <= wrap_d;  kb <= ka; nb <= na; db <= da;
      r_c <= abs_d + DW'(HALF); kc <= kb; nc <= nb; dc <= db;
      m_tdata    <= kc ? '0 : ang;
      m_tuser[0] <= dc;
    end
  end

  // ---- checks ----
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("degenerate result with nonzero angle");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !va && !v0)
    else $error("pipeline valid bits survive reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(vc) && $stable(va))
    else $error("pipeline moved during stall");

endmodule
